// ===== hdl/scrd_pkg.sv =====
// Shared types, constants and tables for the spherical camera ray direction block.
// No dependencies; every other file in hdl imports this package.
`default_nettype none
package scrd_pkg;

   localparam int CORDIC_STAGES_DEF = 16;

   // Divider geometry: divisor s*r*360 fits 38 bits, numerator n*2^21 + d/2 fits 69 bits.
   localparam int DIV_W = 38;
   localparam int NUM_W = 69;
   localparam int QUO_W = 32;
   localparam int CV_W  = 34;

   localparam logic signed [CV_W-1:0] CORDIC_GAIN = 34'sd652032874;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] REG_H_RES   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_V_RES   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PIX     = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_H_ANGLE = 8'd3;
   localparam logic [CSR_IDX_W-1:0] REG_V_ANGLE = 8'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BASIS_U = 8'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BASIS_V = 8'd6;
   localparam logic [CSR_IDX_W-1:0] REG_BASIS_W = 8'd7;

   localparam logic [12:0] H_RES_RST   = 13'd512;
   localparam logic [12:0] V_RES_RST   = 13'd512;
   localparam logic [15:0] PIX_RST     = 16'd256;
   localparam logic [15:0] H_ANGLE_RST = 16'd46080;
   localparam logic [14:0] V_ANGLE_RST = 15'd23040;
   localparam logic [47:0] BASIS_U_RST = 48'h0000_0000_4000;
   localparam logic [47:0] BASIS_V_RST = 48'h0000_4000_0000;
   localparam logic [47:0] BASIS_W_RST = 48'h4000_0000_0000;
   localparam logic [28:0] SR_RST      = 29'd131072;
   localparam logic [DIV_W-1:0] D_RST  = 38'd47185920;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [NUM_W-1:0] num;
      logic [QUO_W-1:0] quo;
      logic             neg;
   } div_lane_type;

   typedef struct packed {
      logic signed [CV_W-1:0] x;
      logic signed [CV_W-1:0] y;
      logic signed [CV_W-1:0] z;
      logic                   flip;
   } cord_lane_type;

   // Arctangent of 2^-i as a binary angle (2^32 per turn).
   function automatic logic [31:0] atan_bam(input int i);
      logic [31:0] a;
      case (i)
         0:  a = 32'h20000000;
         1:  a = 32'h12E4051E;
         2:  a = 32'h09FB385B;
         3:  a = 32'h051111D4;
         4:  a = 32'h028B0D43;
         5:  a = 32'h0145D7E1;
         6:  a = 32'h00A2F61E;
         7:  a = 32'h00517C55;
         8:  a = 32'h0028BE53;
         9:  a = 32'h00145F2F;
         10: a = 32'h000A2F98;
         11: a = 32'h000517CC;
         12: a = 32'h00028BE6;
         13: a = 32'h000145F3;
         14: a = 32'h0000A2FA;
         15: a = 32'h0000517D;
         16: a = 32'h000028BE;
         17: a = 32'h0000145F;
         18: a = 32'h00000A30;
         19: a = 32'h00000518;
         20: a = 32'h0000028C;
         21: a = 32'h00000146;
         22: a = 32'h000000A3;
         23: a = 32'h00000051;
         default: a = 32'h0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/scrd_div_cell.sv =====
// One restoring-division step for both angle axes, registered.
// Depends on scrd_pkg for the lane type and widths.
`default_nettype none
module scrd_div_cell
   import scrd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire logic [DIV_W-1:0] d_x,
   input  wire logic [DIV_W-1:0] d_y,
   input  wire logic             up_vld,
   input  wire div_lane_type     up_x,
   input  wire div_lane_type     up_y,
   output logic                  vld_ff,
   output div_lane_type          lane_x_ff,
   output div_lane_type          lane_y_ff
);

   function automatic div_lane_type div_step(input div_lane_type a, input logic [DIV_W-1:0] d);
      logic [DIV_W:0] trial;
      logic [DIV_W:0] diff;
      logic           ge;
      div_lane_type   r;
      trial = {a.rem, a.num[NUM_W-1]};
      diff  = trial - {1'b0, d};
      ge    = trial >= {1'b0, d};
      r.rem = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      r.num = {a.num[NUM_W-2:0], 1'b0};
      r.quo = {a.quo[QUO_W-2:0], ge};
      r.neg = a.neg;
      return r;
   endfunction

   div_lane_type lane_x_in, lane_y_in;

   assign lane_x_in = div_step(up_x, d_x);
   assign lane_y_in = div_step(up_y, d_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= up_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane_x_ff <= lane_x_in;
         lane_y_ff <= lane_y_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/scrd_cordic_cell.sv =====
// One CORDIC rotation step for the azimuth and polar angles, registered.
// Depends on scrd_pkg for the lane type and the arctangent table.
`default_nettype none
module scrd_cordic_cell
   import scrd_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          adv,
   input  wire logic          up_vld,
   input  wire cord_lane_type up_p,
   input  wire cord_lane_type up_t,
   output logic               vld_ff,
   output cord_lane_type      lane_p_ff,
   output cord_lane_type      lane_t_ff
);

   localparam logic signed [CV_W-1:0] ATAN = signed'({2'b00, atan_bam(STAGE)});

   function automatic cord_lane_type rot_step(input cord_lane_type a);
      logic signed [CV_W-1:0] dx;
      logic signed [CV_W-1:0] dy;
      cord_lane_type          r;
      dx = a.y >>> STAGE;
      dy = a.x >>> STAGE;
      r.flip = a.flip;
      if (!a.z[CV_W-1]) begin
         r.x = a.x - dx;
         r.y = a.y + dy;
         r.z = a.z - ATAN;
      end else begin
         r.x = a.x + dx;
         r.y = a.y - dy;
         r.z = a.z + ATAN;
      end
      return r;
   endfunction

   cord_lane_type lane_p_in, lane_t_in;

   assign lane_p_in = rot_step(up_p);
   assign lane_t_in = rot_step(up_t);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= up_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane_p_ff <= lane_p_in;
         lane_t_ff <= lane_t_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/scrd_combine.sv =====
// Basis combination: nine coefficient-by-component products, then sum, round, saturate.
// Depends on scrd_pkg; holds the result register.
`default_nettype none
module scrd_combine
   import scrd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               up_vld,
   input  wire logic signed [31:0] ku,
   input  wire logic signed [31:0] kv,
   input  wire logic signed [31:0] kw,
   input  wire logic [47:0]        basis_u,
   input  wire logic [47:0]        basis_v,
   input  wire logic [47:0]        basis_w,
   output logic                    rsp_valid,
   output logic signed [15:0]      dir_ff [3]
);

   localparam logic signed [49:0] RND = 50'sd536870912;
   localparam logic signed [19:0] POS = 20'sd32767;
   localparam logic signed [19:0] NEG = -20'sd32768;

   logic                      prod_vld_ff;
   logic signed [47:0]        pu_ff [3];
   logic signed [47:0]        pv_ff [3];
   logic signed [47:0]        pw_ff [3];
   logic signed [15:0]        dir_in [3];

   always_comb begin
      logic signed [49:0] acc;
      logic signed [19:0] v;
      for (int c = 0; c < 3; c++) begin
         acc = 50'(pu_ff[c]) + 50'(pv_ff[c]) + 50'(pw_ff[c]) + RND;
         v   = acc[49:30];
         if (v > POS) begin
            dir_in[c] = POS[15:0];
         end else if (v < NEG) begin
            dir_in[c] = NEG[15:0];
         end else begin
            dir_in[c] = v[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         rsp_valid   <= 1'b0;
      end else if (adv) begin
         prod_vld_ff <= up_vld;
         rsp_valid   <= prod_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            pu_ff[c]  <= ku * signed'(basis_u[16*c +: 16]);
            pv_ff[c]  <= kv * signed'(basis_v[16*c +: 16]);
            pw_ff[c]  <= kw * signed'(basis_w[16*c +: 16]);
            dir_ff[c] <= dir_in[c];
         end
      end
   end

endmodule
`default_nettype wire

// ===== hdl/spherical_camera_ray_direction.sv =====
// Spherical panoramic camera ray direction. One sample point is taken per clock and one
// direction leaves per clock unless the output stalls. A sample runs through the divider
// chain (69 cells, one quotient bit each, turning the scaled point into a binary angle)
// followed by the CORDIC chain (one rotation cell per stage) and the product stages.
// A stalled output freezes the whole pipeline. Write configuration only while idle;
// a new divisor passes the size product register, then the divisor register, after a write.
`default_nettype none
module spherical_camera_ray_direction
   import scrd_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic signed [31:0]   req_plane_x,
   input  wire logic signed [31:0]   req_plane_y,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [15:0]        rsp_dir_x,
   output logic signed [15:0]        rsp_dir_y,
   output logic signed [15:0]        rsp_dir_z,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [47:0]          csr_data
);

   logic adv;

   // configuration
   logic [12:0]      h_res_ff, v_res_ff;
   logic [15:0]      pix_ff, h_ang_ff;
   logic [14:0]      v_ang_ff;
   logic [47:0]      u_ff, v_ff, w_ff;
   logic [28:0]      sr_h_ff, sr_v_ff, sr_h_in, sr_v_in;
   logic [DIV_W-1:0] dh_ff, dv_ff;
   logic [15:0]      pix_eff;
   logic [12:0]      h_eff, v_eff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_res_ff <= H_RES_RST;
         v_res_ff <= V_RES_RST;
         pix_ff   <= PIX_RST;
         h_ang_ff <= H_ANGLE_RST;
         v_ang_ff <= V_ANGLE_RST;
         u_ff     <= BASIS_U_RST;
         v_ff     <= BASIS_V_RST;
         w_ff     <= BASIS_W_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_H_RES:   h_res_ff <= csr_data[12:0];
            REG_V_RES:   v_res_ff <= csr_data[12:0];
            REG_PIX:     pix_ff   <= csr_data[15:0];
            REG_H_ANGLE: h_ang_ff <= csr_data[15:0];
            REG_V_ANGLE: v_ang_ff <= csr_data[14:0];
            REG_BASIS_U: u_ff     <= csr_data;
            REG_BASIS_V: v_ff     <= csr_data;
            REG_BASIS_W: w_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // zero divisor parts read as one
   assign pix_eff = (pix_ff == '0) ? 16'd1 : pix_ff;
   assign h_eff   = (h_res_ff == '0) ? 13'd1 : h_res_ff;
   assign v_eff   = (v_res_ff == '0) ? 13'd1 : v_res_ff;
   assign sr_h_in = 29'(pix_eff) * 29'(h_eff);
   assign sr_v_in = 29'(pix_eff) * 29'(v_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sr_h_ff <= SR_RST;
         sr_v_ff <= SR_RST;
         dh_ff   <= D_RST;
         dv_ff   <= D_RST;
      end else begin
         sr_h_ff <= sr_h_in;
         sr_v_ff <= sr_v_in;
         dh_ff   <= DIV_W'(sr_h_ff) * DIV_W'(360);
         dv_ff   <= DIV_W'(sr_v_ff) * DIV_W'(360);
      end
   end

   // stage 0: input register; stage 1: magnitude times half angle; stage 2: numerator
   logic               s0_vld_ff, s1_vld_ff, s2_vld_ff;
   logic signed [31:0] s0_px_ff, s0_py_ff;
   logic [31:0]        mag_x, mag_y;
   logic [47:0]        n_x_ff, n_y_ff;
   logic               neg_x_ff, neg_y_ff;
   div_lane_type       s2_x_in, s2_y_in, s2_x_ff, s2_y_ff;

   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   assign mag_x = s0_px_ff[31] ? 32'(32'd0 - s0_px_ff) : s0_px_ff;
   assign mag_y = s0_py_ff[31] ? 32'(32'd0 - s0_py_ff) : s0_py_ff;

   always_comb begin
      s2_x_in.rem = '0;
      s2_x_in.quo = '0;
      s2_x_in.neg = neg_x_ff;
      s2_x_in.num = {n_x_ff, 21'd0} + NUM_W'(dh_ff[DIV_W-1:1]);
      s2_y_in.rem = '0;
      s2_y_in.quo = '0;
      s2_y_in.neg = neg_y_ff;
      s2_y_in.num = {n_y_ff, 21'd0} + NUM_W'(dv_ff[DIV_W-1:1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req_valid;
         s1_vld_ff <= s0_vld_ff;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_px_ff <= req_plane_x;
         s0_py_ff <= req_plane_y;
         n_x_ff   <= 48'(mag_x) * 48'(h_ang_ff);
         n_y_ff   <= 48'(mag_y) * 48'(v_ang_ff);
         neg_x_ff <= s0_px_ff[31];
         neg_y_ff <= s0_py_ff[31];
         s2_x_ff  <= s2_x_in;
         s2_y_ff  <= s2_y_in;
      end
   end

   // divider chain
   logic         dvld [NUM_W+1];
   div_lane_type dlx  [NUM_W+1];
   div_lane_type dly  [NUM_W+1];

   assign dvld[0] = s2_vld_ff;
   assign dlx[0]  = s2_x_ff;
   assign dly[0]  = s2_y_ff;

   for (genvar k = 0; k < NUM_W; k++) begin : g_div
      scrd_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .d_x       (dh_ff),
         .d_y       (dv_ff),
         .up_vld    (dvld[k]),
         .up_x      (dlx[k]),
         .up_y      (dly[k]),
         .vld_ff    (dvld[k+1]),
         .lane_x_ff (dlx[k+1]),
         .lane_y_ff (dly[k+1])
      );
   end

   // angle set-up: phi = half turn - lambda, theta = quarter turn - psi, fold to +-90 deg
   function automatic cord_lane_type cord_init(input logic [31:0] a);
      logic [31:0]   ar;
      cord_lane_type r;
      r.flip = a[31] ^ a[30];
      ar     = r.flip ? {~a[31], a[30:0]} : a;
      r.x    = CORDIC_GAIN;
      r.y    = '0;
      r.z    = signed'({{2{ar[31]}}, ar});
      return r;
   endfunction

   logic [31:0]   lam, psi, phi, theta;
   logic          ca_vld_ff;
   cord_lane_type ca_p_ff, ca_t_ff;

   assign lam   = dlx[NUM_W].neg ? 32'(32'd0 - dlx[NUM_W].quo) : dlx[NUM_W].quo;
   assign psi   = dly[NUM_W].neg ? 32'(32'd0 - dly[NUM_W].quo) : dly[NUM_W].quo;
   assign phi   = 32'h8000_0000 - lam;
   assign theta = 32'h4000_0000 - psi;

   always_ff @(posedge clock) begin
      if (reset) begin
         ca_vld_ff <= 1'b0;
      end else if (adv) begin
         ca_vld_ff <= dvld[NUM_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ca_p_ff <= cord_init(phi);
         ca_t_ff <= cord_init(theta);
      end
   end

   // CORDIC chain
   logic          cvld [CORDIC_STAGES+1];
   cord_lane_type clp  [CORDIC_STAGES+1];
   cord_lane_type clt  [CORDIC_STAGES+1];

   assign cvld[0] = ca_vld_ff;
   assign clp[0]  = ca_p_ff;
   assign clt[0]  = ca_t_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      scrd_cordic_cell #(.STAGE(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .up_vld    (cvld[i]),
         .up_p      (clp[i]),
         .up_t      (clt[i]),
         .vld_ff    (cvld[i+1]),
         .lane_p_ff (clp[i+1]),
         .lane_t_ff (clt[i+1])
      );
   end

   // unfold, then coefficient products
   logic                   cb_vld_ff, cc_vld_ff;
   logic signed [31:0]     cp_ff, sp_ff, ct_ff, st_ff;
   logic signed [CV_W-1:0] cp_w, sp_w, ct_w, st_w;
   logic signed [31:0]     ku_ff, kv_ff, kw_ff;
   logic signed [63:0]     ku_in, kw_in;

   assign cp_w = clp[CORDIC_STAGES].flip ? -clp[CORDIC_STAGES].x : clp[CORDIC_STAGES].x;
   assign sp_w = clp[CORDIC_STAGES].flip ? -clp[CORDIC_STAGES].y : clp[CORDIC_STAGES].y;
   assign ct_w = clt[CORDIC_STAGES].flip ? -clt[CORDIC_STAGES].x : clt[CORDIC_STAGES].x;
   assign st_w = clt[CORDIC_STAGES].flip ? -clt[CORDIC_STAGES].y : clt[CORDIC_STAGES].y;

   assign ku_in = st_ff * sp_ff + 64'sd536870912;
   assign kw_in = st_ff * cp_ff + 64'sd536870912;

   always_ff @(posedge clock) begin
      if (reset) begin
         cb_vld_ff <= 1'b0;
         cc_vld_ff <= 1'b0;
      end else if (adv) begin
         cb_vld_ff <= cvld[CORDIC_STAGES];
         cc_vld_ff <= cb_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cp_ff <= cp_w[31:0];
         sp_ff <= sp_w[31:0];
         ct_ff <= ct_w[31:0];
         st_ff <= st_w[31:0];
         ku_ff <= ku_in[61:30];
         kw_ff <= kw_in[61:30];
         kv_ff <= ct_ff;
      end
   end

   logic signed [15:0] dir_ff [3];

   scrd_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .up_vld    (cc_vld_ff),
      .ku        (ku_ff),
      .kv        (kv_ff),
      .kw        (kw_ff),
      .basis_u   (u_ff),
      .basis_v   (v_ff),
      .basis_w   (w_ff),
      .rsp_valid (rsp_valid),
      .dir_ff    (dir_ff)
   );

   assign rsp_dir_x = dir_ff[0];
   assign rsp_dir_y = dir_ff[1];
   assign rsp_dir_z = dir_ff[2];

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output is held");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> rsp_valid)
      else $error("result lost during stall");

   a_entry: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s0_vld_ff)
      else $error("accepted beat did not enter the pipeline");

   a_divisor: assert property (@(posedge clock) disable iff (reset)
      dh_ff != '0 && dv_ff != '0)
      else $error("zero divisor reached the divider chain");

endmodule
`default_nettype wire
